[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk outside reset.
`define CBF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, during reset as well.
`define CBF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/cbf_pkg.sv]
// ----------------------------------------------------------------------------
// Clipped blit fill engine package
// Widths, codes, reset values and shared types of the blitter.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int ADDR_BITS_DEF    = 24;
    localparam int COARSE_SHIFT_DEF = 4;

    localparam int CNT_W      = 12;
    localparam int STRIDE_W   = 16;
    localparam int SIZE_W     = 24;
    localparam int POS_W      = 16;
    localparam int DIM_W      = 8;
    localparam int PIX_W      = 8;
    localparam int MODE_W     = 3;
    localparam int PROD_W     = STRIDE_W + POS_W;
    localparam int WR_ADDR_W  = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_FB_STRIDE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_SIZE   = 8'd1;

    localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd320;
    localparam logic [SIZE_W-1:0]   SIZE_RST   = 24'd76800;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_HLINE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_VLINE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CRECT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PRECT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BKG    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SPRITE = 3'd5;

    typedef struct packed {
        logic [STRIDE_W-1:0] stride;
        logic [SIZE_W-1:0]   size;
    } cbf_cfg_t;

    typedef struct packed {
        logic              cmd;
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos_x;
        logic [DIM_W-1:0]  size_w;
        logic [DIM_W-1:0]  size_h;
        logic [PIX_W-1:0]  fill_color;
        logic [PIX_W-1:0]  src_pixel;
        logic [PROD_W-1:0] row_offset;
    } cbf_item_t;

endpackage

[hw/rtl/clipped_blit_fill_engine.sv]
// ----------------------------------------------------------------------------
// Clipped blit fill engine
// Rectangle, line, copy and sprite blitter for an 8-bit indexed framebuffer.
// ----------------------------------------------------------------------------
// A start beat (cmd 0) loads a shape and gives no result. Each step beat
// (cmd 1) while a shape is active gives one result beat: a pixel write, a
// transparent sprite pixel, or a clipped end once the address reaches
// fb_size. Steps with no active shape give no result.
// The input channel (item_valid, item_stall) feeds an input register; the
// start row offset fb_stride * pos_y is formed on the way into it. The
// drawing core then updates the shape state and loads the result register.
// A step beat passes through the input register and then the result register,
// and the block sustains one beat per cycle on both channels when not stalled.
// When the receiver stalls, the result register holds its beat and one more
// input beat is still taken; item_stall rises only while both are full and
// the waiting beat needs an output slot.
// Configuration writes (cfg_valid, cfg_ready, always ready) must be made
// while the block is idle; the block does not enforce it. Reset clears all
// shape state, leaves the block idle, loads fb_stride 320 and fb_size 76800.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clipped_blit_fill_engine
#(
    parameter int ADDR_BITS    = cbf_pkg::ADDR_BITS_DEF,
    parameter int COARSE_SHIFT = cbf_pkg::COARSE_SHIFT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic                           cmd,
    input  logic [cbf_pkg::MODE_W-1:0]     mode,
    input  logic [cbf_pkg::POS_W-1:0]      pos_x,
    input  logic [cbf_pkg::POS_W-1:0]      pos_y,
    input  logic [cbf_pkg::DIM_W-1:0]      size_w,
    input  logic [cbf_pkg::DIM_W-1:0]      size_h,
    input  logic [cbf_pkg::PIX_W-1:0]      fill_color,
    input  logic [cbf_pkg::PIX_W-1:0]      src_pixel,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic                           write_en,
    output logic [cbf_pkg::WR_ADDR_W-1:0]  wr_addr,
    output logic [cbf_pkg::PIX_W-1:0]      wr_pixel,
    output logic                           done_res,
    output logic                           clipped
);

    cbf_pkg::cbf_cfg_t  cfg;
    cbf_pkg::cbf_item_t beat;
    logic               beat_valid;
    logic               beat_take;

    assign cfg_ready = 1'b1;

    cbf_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cbf_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (cmd),
        .mode       (mode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .size_w     (size_w),
        .size_h     (size_h),
        .fill_color (fill_color),
        .src_pixel  (src_pixel),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    cbf_core
    #(
        .ADDR_BITS    (ADDR_BITS),
        .COARSE_SHIFT (COARSE_SHIFT)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .write_en   (write_en),
        .wr_addr    (wr_addr),
        .wr_pixel   (wr_pixel),
        .done_res   (done_res),
        .clipped    (clipped)
    );

    // A clipped beat always ends the shape and never writes.
    `CBF_ASSERT(a_clip_ends, res_valid && clipped |-> done_res && !write_en, "bad clipped beat")

    // A beat that writes nothing carries a zero pixel.
    `CBF_ASSERT(a_idle_pixel, res_valid && !write_en |-> wr_pixel == '0, "nonzero idle pixel")

    // The input side stalls only while the input register holds a beat.
    `CBF_ASSERT_ALWAYS(a_stall_full, item_stall |-> beat_valid, "stall while empty")

    // A held beat is blocked only by a full result register under stall.
    `CBF_ASSERT(a_hold_cause, beat_valid && !beat_take |-> res_valid && res_stall, "needless hold")

endmodule

[hw/rtl/cbf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the framebuffer row pitch and the clipping bound.
// ----------------------------------------------------------------------------
module cbf_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [cbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbf_pkg::CFG_DATA_W-1:0] cfg_data,
    output cbf_pkg::cbf_cfg_t              cfg
);

    logic [cbf_pkg::STRIDE_W-1:0] stride_reg;
    logic [cbf_pkg::SIZE_W-1:0]   size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= cbf_pkg::STRIDE_RST;
            size_reg   <= cbf_pkg::SIZE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cbf_pkg::CFG_FB_STRIDE: stride_reg <= cfg_data[cbf_pkg::STRIDE_W-1:0];
                cbf_pkg::CFG_FB_SIZE:   size_reg   <= cfg_data[cbf_pkg::SIZE_W-1:0];
                default:                ;
            endcase
        end
    end

    assign cfg.stride = stride_reg;
    assign cfg.size   = size_reg;

endmodule

[hw/rtl/cbf_in_stage.sv]
// ----------------------------------------------------------------------------
// Input stage
// Registers one input beat and forms the row offset of a start position.
// ----------------------------------------------------------------------------
module cbf_in_stage
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cbf_pkg::cbf_cfg_t            cfg,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         cmd,
    input  logic [cbf_pkg::MODE_W-1:0]   mode,
    input  logic [cbf_pkg::POS_W-1:0]    pos_x,
    input  logic [cbf_pkg::POS_W-1:0]    pos_y,
    input  logic [cbf_pkg::DIM_W-1:0]    size_w,
    input  logic [cbf_pkg::DIM_W-1:0]    size_h,
    input  logic [cbf_pkg::PIX_W-1:0]    fill_color,
    input  logic [cbf_pkg::PIX_W-1:0]    src_pixel,
    output logic                         beat_valid,
    output cbf_pkg::cbf_item_t           beat,
    input  logic                         beat_take
);

    logic               valid_reg;
    logic               valid_next;
    cbf_pkg::cbf_item_t beat_reg;
    cbf_pkg::cbf_item_t beat_next;
    logic               accept;

    assign item_stall = valid_reg && !beat_take;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        beat_next.cmd        = cmd;
        beat_next.mode       = mode;
        beat_next.pos_x      = pos_x;
        beat_next.size_w     = size_w;
        beat_next.size_h     = size_h;
        beat_next.fill_color = fill_color;
        beat_next.src_pixel  = src_pixel;
        beat_next.row_offset = cbf_pkg::PROD_W'(cfg.stride) * cbf_pkg::PROD_W'(pos_y);
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (beat_take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

[hw/rtl/cbf_core.sv]
// ----------------------------------------------------------------------------
// Drawing core
// Shape state, raster walk with clipping, and the result register.
// ----------------------------------------------------------------------------
module cbf_core
#(
    parameter int ADDR_BITS    = cbf_pkg::ADDR_BITS_DEF,
    parameter int COARSE_SHIFT = cbf_pkg::COARSE_SHIFT_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cbf_pkg::cbf_cfg_t               cfg,
    input  logic                            beat_valid,
    input  cbf_pkg::cbf_item_t              beat,
    output logic                            beat_take,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic                            write_en,
    output logic [cbf_pkg::WR_ADDR_W-1:0]   wr_addr,
    output logic [cbf_pkg::PIX_W-1:0]       wr_pixel,
    output logic                            done_res,
    output logic                            clipped
);

    localparam int WIDE_W = 34;
    localparam int EXT_W  = ADDR_BITS + cbf_pkg::WR_ADDR_W;
    localparam int SZ_W   = cbf_pkg::DIM_W + COARSE_SHIFT + cbf_pkg::CNT_W;
    localparam logic [WIDE_W-1:0] ADDR_MAX = (WIDE_W'(1) << ADDR_BITS) - WIDE_W'(1);

    logic                            active_reg,   active_next;
    logic [cbf_pkg::MODE_W-1:0]      mode_reg,     mode_next;
    logic [ADDR_BITS-1:0]            addr_reg,     addr_next;
    logic [cbf_pkg::CNT_W-1:0]       col_reg,      col_next;
    logic [cbf_pkg::CNT_W-1:0]       row_reg,      row_next;
    logic [cbf_pkg::CNT_W-1:0]       shape_w_reg,  shape_w_next;
    logic [cbf_pkg::CNT_W-1:0]       shape_h_reg,  shape_h_next;
    logic [cbf_pkg::PIX_W-1:0]       color_reg,    color_next;

    logic                            res_valid_reg, res_valid_next;
    logic                            write_en_reg,  write_en_next;
    logic [cbf_pkg::WR_ADDR_W-1:0]   wr_addr_reg,   wr_addr_next;
    logic [cbf_pkg::PIX_W-1:0]       wr_pixel_reg,  wr_pixel_next;
    logic                            done_reg,      done_next;
    logic                            clipped_reg,   clipped_next;

    logic                            has_res;
    logic                            out_free;
    logic [SZ_W-1:0]                 cw_wide;
    logic [SZ_W-1:0]                 ch_wide;
    logic [cbf_pkg::CNT_W-1:0]       cw;
    logic [cbf_pkg::CNT_W-1:0]       ch;
    logic [WIDE_W-1:0]               start_sum;
    logic [WIDE_W-1:0]               next_col_addr;
    logic [WIDE_W-1:0]               next_row_addr;
    logic [cbf_pkg::CNT_W:0]         col_inc;
    logic [cbf_pkg::CNT_W:0]         row_inc;
    logic [EXT_W-1:0]                addr_ext;
    logic [cbf_pkg::PIX_W-1:0]       pix;
    logic                            pix_wr;

    function automatic logic [ADDR_BITS-1:0] sat_addr(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] s;
        s = (v > ADDR_MAX) ? ADDR_MAX : v;
        return s[ADDR_BITS-1:0];
    endfunction

    assign cw_wide = SZ_W'(beat.size_w) << COARSE_SHIFT;
    assign ch_wide = SZ_W'(beat.size_h) << COARSE_SHIFT;
    assign cw = (cw_wide > SZ_W'(cbf_pkg::CNT_MAX)) ? cbf_pkg::CNT_MAX
                                                     : cw_wide[cbf_pkg::CNT_W-1:0];
    assign ch = (ch_wide > SZ_W'(cbf_pkg::CNT_MAX)) ? cbf_pkg::CNT_MAX
                                                     : ch_wide[cbf_pkg::CNT_W-1:0];

    assign start_sum     = WIDE_W'(beat.pos_x) + WIDE_W'(beat.row_offset);
    assign next_col_addr = WIDE_W'(addr_reg) + WIDE_W'(1);
    assign next_row_addr = WIDE_W'(addr_reg) + WIDE_W'(1) + WIDE_W'(cfg.stride)
                           - WIDE_W'(shape_w_reg);
    assign col_inc  = (cbf_pkg::CNT_W+1)'(col_reg) + (cbf_pkg::CNT_W+1)'(1);
    assign row_inc  = (cbf_pkg::CNT_W+1)'(row_reg) + (cbf_pkg::CNT_W+1)'(1);
    assign addr_ext = EXT_W'(addr_reg);

    assign pix    = (mode_reg == cbf_pkg::MODE_BKG || mode_reg == cbf_pkg::MODE_SPRITE)
                    ? beat.src_pixel : color_reg;
    assign pix_wr = !(mode_reg == cbf_pkg::MODE_SPRITE && pix == '0);

    always_comb
    begin
        active_next   = active_reg;
        mode_next     = mode_reg;
        addr_next     = addr_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        shape_w_next  = shape_w_reg;
        shape_h_next  = shape_h_reg;
        color_next    = color_reg;
        has_res       = 1'b0;
        write_en_next = 1'b0;
        wr_addr_next  = addr_ext[cbf_pkg::WR_ADDR_W-1:0];
        wr_pixel_next = '0;
        done_next     = 1'b0;
        clipped_next  = 1'b0;

        if (beat.cmd == cbf_pkg::CMD_START)
        begin
            case (beat.mode)
                cbf_pkg::MODE_HLINE:
                begin
                    shape_w_next = cw;
                    shape_h_next = cbf_pkg::CNT_W'(1);
                end
                cbf_pkg::MODE_VLINE:
                begin
                    shape_w_next = cbf_pkg::CNT_W'(1);
                    shape_h_next = ch;
                end
                cbf_pkg::MODE_CRECT, cbf_pkg::MODE_BKG:
                begin
                    shape_w_next = cw;
                    shape_h_next = ch;
                end
                cbf_pkg::MODE_PRECT, cbf_pkg::MODE_SPRITE:
                begin
                    shape_w_next = cbf_pkg::CNT_W'(beat.size_w);
                    shape_h_next = cbf_pkg::CNT_W'(beat.size_h);
                end
                default:
                begin
                    shape_w_next = '0;
                    shape_h_next = '0;
                end
            endcase
            mode_next   = beat.mode;
            col_next    = '0;
            row_next    = '0;
            color_next  = beat.fill_color;
            addr_next   = sat_addr(start_sum);
            active_next = (shape_w_next != '0) && (shape_h_next != '0);
        end
        else if (active_reg)
        begin
            has_res = 1'b1;
            if (WIDE_W'(addr_reg) >= WIDE_W'(cfg.size))
            begin
                done_next    = 1'b1;
                clipped_next = 1'b1;
                active_next  = 1'b0;
            end
            else
            begin
                write_en_next = pix_wr;
                wr_pixel_next = pix_wr ? pix : '0;
                if (col_inc >= (cbf_pkg::CNT_W+1)'(shape_w_reg))
                begin
                    col_next  = '0;
                    row_next  = row_inc[cbf_pkg::CNT_W-1:0];
                    addr_next = sat_addr(next_row_addr);
                    if (row_inc >= (cbf_pkg::CNT_W+1)'(shape_h_reg))
                    begin
                        done_next   = 1'b1;
                        active_next = 1'b0;
                    end
                end
                else
                begin
                    col_next  = col_inc[cbf_pkg::CNT_W-1:0];
                    addr_next = sat_addr(next_col_addr);
                end
            end
        end
    end

    assign out_free  = !res_valid_reg || !res_stall;
    assign beat_take = beat_valid && (!has_res || out_free);

    always_comb
    begin
        if (beat_take && has_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            mode_reg      <= '0;
            addr_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            shape_w_reg   <= '0;
            shape_h_reg   <= '0;
            color_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (beat_take)
            begin
                active_reg  <= active_next;
                mode_reg    <= mode_next;
                addr_reg    <= addr_next;
                col_reg     <= col_next;
                row_reg     <= row_next;
                shape_w_reg <= shape_w_next;
                shape_h_reg <= shape_h_next;
                color_reg   <= color_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_take && has_res)
        begin
            write_en_reg <= write_en_next;
            wr_addr_reg  <= wr_addr_next;
            wr_pixel_reg <= wr_pixel_next;
            done_reg     <= done_next;
            clipped_reg  <= clipped_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign write_en  = write_en_reg;
    assign wr_addr   = wr_addr_reg;
    assign wr_pixel  = wr_pixel_reg;
    assign done_res  = done_reg;
    assign clipped   = clipped_reg;

endmodule
